/* rtl/lfu_pkg.sv */
// Shared types and constants for the LFU cache policy block.
// Used by the channel interfaces and by the top level; no dependencies.
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_ONE   = 32'd1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIX,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TOUCH,
    MODE_INSERT
  } mode_t;

endpackage

/* rtl/lfu_ifs.sv */
// Valid/ready channel interfaces for the LFU cache policy block.
// Depends on lfu_pkg for field widths.
interface lfu_in_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

/* rtl/lfu_cache_policy.sv */
// LFU cache with LRU tie break: one shared scan/compare unit over an entry memory.
// Depends on lfu_pkg and the channel interfaces in lfu_ifs.sv.
//
//  Port      Dir  Fields                                      Transfer
//  in_chan   in   action, key, value                          valid & ready
//  out_chan  out  hit, read_value, evicted, evicted_key       valid & ready
//  cfg_chan  in   capacity                                    valid & ready (always ready)
//
//  An item takes a lookup pass over the entry memory (one entry a cycle through the read
//  port), a decision step, an update pass that rewrites each entry, and the result load.
//  A get miss or an ignored put skips the update pass. After reset a clearing pass
//  invalidates the memory; in_chan is not ready until it ends. The next item is taken
//  while a result waits in the output register.
module lfu_cache_policy import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lfu_in_if.sink    in_chan,
  lfu_out_if.source out_chan,
  lfu_cfg_if.sink   cfg_chan
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // entry memory, one row per entry, all fields share the address
  logic             vld_mem  [ENTRIES];
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [CNT_W-1:0] cnt_mem  [ENTRIES];
  logic [RW-1:0]    rank_mem [ENTRIES];

  state_t state_r, state_nxt;

  logic [CAP_W-1:0] capacity_r;
  logic [OW-1:0]    occ_r;
  logic [OW-1:0]    cap_eff;

  logic             act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic [IW-1:0] addr_r;
  logic          iss_r;
  logic          rd_v_r;
  logic [IW-1:0] rd_idx_r;

  logic             rd_vld_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [RW-1:0]    rd_rank_r;

  // lookup trackers
  logic             hit_r;
  logic [IW-1:0]    e_idx_r;
  logic [RW-1:0]    e_rank_r;
  logic [VAL_W-1:0] e_val_r;
  logic             v_found_r;
  logic [IW-1:0]    v_idx_r;
  logic [CNT_W-1:0] v_cnt_r;
  logic [RW-1:0]    v_rank_r;
  logic [KEY_W-1:0] v_key_r;
  logic             free_found_r;
  logic [IW-1:0]    free_idx_r;

  // decision
  mode_t            mode_r;
  logic             evict_r;
  logic [IW-1:0]    slot_r;
  logic [VAL_W-1:0] res_rd_r;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_rd_r;
  logic             out_ev_r;
  logic [KEY_W-1:0] out_evk_r;

  // sequencer outputs
  logic in_ready;
  logic pass_start;
  logic load_out;
  logic we;

  logic             in_xfer;
  logic             pass_end;
  logic [31:0]      cap_wide;

  logic             w_vld;
  logic [KEY_W-1:0] w_key;
  logic [VAL_W-1:0] w_val;
  logic [CNT_W-1:0] w_cnt;
  logic [RW-1:0]    w_rank;
  logic [IW-1:0]    w_addr;

  logic             match;
  logic             better;
  logic [CNT_W-1:0] cnt_inc;

  mode_t            mode_dec;
  logic             evict_dec;
  logic [IW-1:0]    slot_dec;
  logic [VAL_W-1:0] rd_dec;

  assign in_xfer  = in_chan.valid & in_ready;
  assign pass_end = rd_v_r && (rd_idx_r == LAST_IDX);

  assign cap_wide = {{(32 - CAP_W){1'b0}}, capacity_r};
  assign cap_eff  = (cap_wide > 32'(ENTRIES)) ? OW'(ENTRIES) : cap_wide[OW-1:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (addr_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_chan.valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (pass_end) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (mode_dec == MODE_NONE) ? ST_OUT : ST_FIX;
      ST_FIX:    if (pass_end) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    pass_start = 1'b0;
    load_out   = 1'b0;
    we         = 1'b0;
    unique case (state_r)
      ST_CLEAR:  we = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   ;
      ST_DECIDE: pass_start = (mode_dec != MODE_NONE);
      ST_FIX:    we = rd_v_r;
      ST_OUT:    load_out = !out_valid_r || out_chan.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- address and read pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      iss_r  <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= iss_r;
      if (in_xfer || pass_start) begin
        addr_r <= '0;
        iss_r  <= 1'b1;
      end else if (state_r == ST_CLEAR || iss_r) begin
        if (addr_r == LAST_IDX) begin
          iss_r  <= 1'b0;
          addr_r <= '0;
        end else begin
          addr_r <= addr_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= addr_r;
    rd_vld_r  <= vld_mem[addr_r];
    rd_key_r  <= key_mem[addr_r];
    rd_val_r  <= val_mem[addr_r];
    rd_cnt_r  <= cnt_mem[addr_r];
    rd_rank_r <= rank_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vld_mem[w_addr]  <= w_vld;
      key_mem[w_addr]  <= w_key;
      val_mem[w_addr]  <= w_val;
      cnt_mem[w_addr]  <= w_cnt;
      rank_mem[w_addr] <= w_rank;
    end
  end

  // ---------------------------------------------------------------- shared compare unit
  assign match  = rd_vld_r && (rd_key_r == key_r);
  assign better = rd_vld_r && (!v_found_r || (rd_cnt_r < v_cnt_r) ||
                               ((rd_cnt_r == v_cnt_r) && (rd_rank_r > v_rank_r)));
  assign cnt_inc = (rd_cnt_r != CNT_MAX) ? (rd_cnt_r + CNT_ONE) : rd_cnt_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r        <= in_chan.action;
      key_r        <= in_chan.key;
      val_r        <= in_chan.value;
      hit_r        <= 1'b0;
      v_found_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == ST_SCAN && rd_v_r) begin
      if (match && !hit_r) begin
        hit_r    <= 1'b1;
        e_idx_r  <= rd_idx_r;
        e_rank_r <= rd_rank_r;
        e_val_r  <= rd_val_r;
      end
      if (better) begin
        v_found_r <= 1'b1;
        v_idx_r   <= rd_idx_r;
        v_cnt_r   <= rd_cnt_r;
        v_rank_r  <= rd_rank_r;
      end
      if (!rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  // key of the victim, captured while the lookup pass passes it
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && rd_v_r && better) v_key_r <= rd_key_r;
  end

  // ---------------------------------------------------------------- decision
  always_comb begin
    mode_dec  = MODE_NONE;
    evict_dec = 1'b0;
    slot_dec  = free_idx_r;
    rd_dec    = '0;
    if (hit_r) begin
      if (act_r == ACT_GET) begin
        rd_dec   = e_val_r;
        mode_dec = MODE_TOUCH;
      end else if (cap_eff != '0) begin
        mode_dec = MODE_TOUCH;
      end
    end else if (act_r == ACT_PUT && cap_eff != '0) begin
      mode_dec = MODE_INSERT;
      if (occ_r >= cap_eff && v_found_r) begin
        evict_dec = 1'b1;
        if (!free_found_r || v_idx_r < free_idx_r) slot_dec = v_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (state_r == ST_DECIDE && mode_dec == MODE_INSERT && !evict_dec) begin
      occ_r <= occ_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      mode_r   <= mode_dec;
      evict_r  <= evict_dec;
      slot_r   <= slot_dec;
      res_rd_r <= rd_dec;
    end
  end

  // ---------------------------------------------------------------- update write-back
  always_comb begin
    w_addr = rd_idx_r;
    w_vld  = rd_vld_r;
    w_key  = rd_key_r;
    w_val  = rd_val_r;
    w_cnt  = rd_cnt_r;
    w_rank = rd_rank_r;
    if (state_r == ST_CLEAR) begin
      w_addr = addr_r;
      w_vld  = 1'b0;
      w_key  = '0;
      w_val  = '0;
      w_cnt  = '0;
      w_rank = '0;
    end else if (mode_r == MODE_TOUCH) begin
      if (rd_idx_r == e_idx_r) begin
        w_cnt  = cnt_inc;
        w_rank = '0;
        if (act_r == ACT_PUT) w_val = val_r;
      end else if (rd_vld_r && rd_rank_r < e_rank_r) begin
        w_rank = rd_rank_r + RW'(1);
      end
    end else begin
      priority if (rd_idx_r == slot_r) begin
        w_vld  = 1'b1;
        w_key  = key_r;
        w_val  = val_r;
        w_cnt  = CNT_ONE;
        w_rank = '0;
      end else if (evict_r && rd_idx_r == v_idx_r) begin
        w_vld = 1'b0;
      end else if (rd_vld_r) begin
        // entries behind the evicted one move up, then all age by one
        if (!(evict_r && rd_rank_r > v_rank_r)) w_rank = rd_rank_r + RW'(1);
      end else begin
        w_vld = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_chan.valid) begin
      capacity_r <= cfg_chan.capacity;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r <= hit_r;
      out_rd_r  <= (mode_r == MODE_NONE) ? '0 : res_rd_r;
      out_ev_r  <= (mode_r == MODE_INSERT) && evict_r;
      out_evk_r <= ((mode_r == MODE_INSERT) && evict_r) ? v_key_r : '0;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.read_value  = out_rd_r;
  assign out_chan.evicted     = out_ev_r;
  assign out_chan.evicted_key = out_evk_r;

  // ---------------------------------------------------------------- checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES))
    else $error("occupancy exceeds entry count");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rd_r != '0) |-> out_hit_r)
    else $error("read value without a hit");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SCAN) && iss_r)
    else $error("lookup pass did not start after input transfer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) || (state_r == ST_SCAN) |-> !we)
    else $error("entry memory written outside clear or update pass");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for lfu_cache_policy: directed and random get/put traffic over several capacities.
// Depends on lfu_pkg, the channel interfaces in lfu_ifs.sv and the block itself.
module testbench;
  import lfu_pkg::*;

  localparam int LINES = 16;

  // Shadow copy of the cache contents plus the queue of outcomes still owed by the block.
  class lfu_shadow;
    typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
    } outcome_t;

    bit               line_valid[LINES];
    logic [KEY_W-1:0] line_key[LINES];
    logic [VAL_W-1:0] line_value[LINES];
    logic [CNT_W-1:0] line_uses[LINES];
    int unsigned      line_age[LINES];
    int unsigned      fill;
    logic [CAP_W-1:0] capacity;
    outcome_t         outcomes_due[$];
    int unsigned      errors;

    function new();
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return outcomes_due.size();
    endfunction

    // Bump the use count (saturating) and make the line the most recent.
    function void promote(int idx);
      int unsigned was;
      was = line_age[idx];
      if (line_uses[idx] != CNT_MAX) line_uses[idx]++;
      for (int i = 0; i < LINES; i++) begin
        if (line_valid[i] && i != idx && line_age[i] < was) line_age[i]++;
      end
      line_age[idx] = 0;
    endfunction

    function void accept_request(logic act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      outcome_t    res;
      int          found;
      int          victim;
      int          slot;
      int unsigned limit;
      int unsigned gone_age;
      res   = '0;
      found = -1;
      for (int i = 0; i < LINES; i++) begin
        if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
      end
      limit   = (capacity > LINES) ? LINES : capacity;
      res.hit = (found >= 0);
      if (act == ACT_GET) begin
        if (found >= 0) begin
          res.read_value = line_value[found];
          promote(found);
        end
      end else if (limit != 0) begin
        if (found >= 0) begin
          line_value[found] = value;
          promote(found);
        end else begin
          if (fill >= limit) begin
            // lowest count wins; among equal counts take the least recent line
            victim = -1;
            for (int i = 0; i < LINES; i++) begin
              if (line_valid[i] && (victim < 0 || line_uses[i] < line_uses[victim] ||
                  (line_uses[i] == line_uses[victim] && line_age[i] > line_age[victim])))
                victim = i;
            end
            if (victim >= 0) begin
              res.evicted      = 1'b1;
              res.evicted_key  = line_key[victim];
              gone_age         = line_age[victim];
              line_valid[victim] = 1'b0;
              for (int i = 0; i < LINES; i++) begin
                if (line_valid[i] && line_age[i] > gone_age) line_age[i]--;
              end
              if (fill > 0) fill--;
            end
          end
          slot = -1;
          for (int i = 0; i < LINES; i++) begin
            if (slot < 0 && !line_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < LINES; i++) begin
              if (line_valid[i]) line_age[i]++;
            end
            line_valid[slot] = 1'b1;
            line_key[slot]   = key;
            line_value[slot] = value;
            line_uses[slot]  = CNT_ONE;
            line_age[slot]   = 0;
            fill++;
          end
        end
      end
      outcomes_due.push_back(res);
    endfunction

    function void check_outcome(logic hit, logic [VAL_W-1:0] read_value, logic evicted,
                                logic [KEY_W-1:0] evicted_key);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        $error("unexpected result: hit=%0b read_value=%h evicted=%0b evicted_key=%h",
               hit, read_value, evicted, evicted_key);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, hit);
        errors++;
      end
      if (read_value !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, read_value);
        errors++;
      end
      if (evicted !== want.evicted) begin
        $error("evicted: expected %0b, got %0b", want.evicted, evicted);
        errors++;
      end
      if (evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lfu_in_if  in_chan ();
  lfu_out_if out_chan ();
  lfu_cfg_if cfg_chan ();

  lfu_cache_policy #(.ENTRIES(LINES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  lfu_shadow   shadow = new();
  int unsigned send_max_gap    = 8;
  int unsigned recv_max_gap    = 8;
  int unsigned hold_off_cycles = 0;

  always #5 clk = ~clk;

  task automatic send_item(logic act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(send_max_gap);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.action <= act;
    in_chan.key    <= key;
    in_chan.value  <= value;
    do @(posedge clk); while (!(in_chan.valid === 1'b1 && in_chan.ready === 1'b1));
    shadow.accept_request(act, key, value);
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (2 * LINES + 8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_chan.valid    <= 1'b1;
    cfg_chan.capacity <= cap;
    do @(posedge clk); while (!(cfg_chan.valid === 1'b1 && cfg_chan.ready === 1'b1));
    shadow.set_capacity(cap);
    cfg_chan.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned pause;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        pause           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        pause = $urandom_range(recv_max_gap);
      end
      if (pause != 0) begin
        out_chan.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid === 1'b1 && out_chan.ready === 1'b1));
      shadow.check_outcome(out_chan.hit, out_chan.read_value, out_chan.evicted,
                           out_chan.evicted_key);
    end
  end

  initial begin
    logic [KEY_W-1:0] pool[$];
    logic [CAP_W-1:0] cap;
    logic             act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    int unsigned      items;
    int unsigned      counted;
    int unsigned      sent;
    int unsigned      limit;
    int unsigned      roll;

    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.action    <= ACT_GET;
    in_chan.key       <= '0;
    in_chan.value     <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.capacity <= CAP_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme keys and values, update in place, zero capacity,
    // capacity below occupancy, LRU tie break, capacity above the line count.
    send_max_gap = 2;
    recv_max_gap = 2;
    write_capacity(CAP_RESET);
    send_item(ACT_GET, '0, '0);
    send_item(ACT_PUT, '0, '1);
    send_item(ACT_PUT, '1, '0);
    send_item(ACT_GET, '0, '0);
    send_item(ACT_PUT, '0, 32'h1234_5678);
    send_item(ACT_GET, '1, '1);
    write_capacity(5'd0);
    send_item(ACT_PUT, 32'h5, 32'hA5A5_A5A5);
    send_item(ACT_GET, '0, '0);
    send_item(ACT_PUT, '1, 32'h1);
    send_item(ACT_GET, '1, '0);
    write_capacity(5'd1);
    send_item(ACT_PUT, 32'h7, 32'h7777_7777);
    send_item(ACT_PUT, 32'h8, 32'h8888_8888);
    write_capacity(5'd3);
    send_item(ACT_PUT, 32'h9, 32'h9999_9999);
    send_item(ACT_PUT, 32'hA, 32'hAAAA_AAAA);
    send_item(ACT_GET, 32'h9, '0);
    send_item(ACT_PUT, 32'hB, 32'hBBBB_BBBB);
    write_capacity(5'd31);
    send_item(ACT_PUT, 32'hC, 32'h5555_5555);
    send_item(ACT_GET, 32'hDEAD_BEEF, '1);

    // Random phases: small key pools so hits, updates and evictions are common.
    for (int p = 0; p < 11; p++) begin
      case (p)
        0:       cap = 5'd31;
        1:       cap = 5'd16;
        2:       cap = 5'd0;
        3:       cap = 5'd1;
        default: cap = ($urandom_range(9) == 0) ? 5'd31 : 5'($urandom_range(17));
      endcase
      send_max_gap = (p % 3 == 1) ? 0 : 8;
      recv_max_gap = (p % 4 == 3) ? 0 : 8;
      items        = (cap == 0) ? 15 : 50;
      limit        = (cap > LINES) ? LINES : cap;
      write_capacity(cap);
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_off_cycles = 300;
      pool.delete();
      repeat (limit + 1 + $urandom_range(limit / 2 + 3)) pool.push_back($urandom);
      counted = 0;
      sent    = 0;
      while (counted < items) begin
        if (p == 3 && sent == items / 2) wait_drained();
        roll = $urandom_range(99);
        if (roll < 2)       key = '0;
        else if (roll < 4)  key = '1;
        else if (roll < 14) key = $urandom;
        else                key = pool[$urandom_range(pool.size() - 1)];
        act   = ($urandom_range(99) < 55) ? ACT_PUT : ACT_GET;
        value = ($urandom_range(19) == 0) ? '1 : VAL_W'($urandom);
        send_item(act, key, value);
        sent++;
        // puts at zero capacity change nothing, so they do not count
        if (!(act == ACT_PUT && cap == 0)) counted++;
      end
    end

    wait_drained();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
